[rtl/core/eaq_pkg.sv]
// ----------------------------------------------------------------------------
// eaq_pkg
// Shared widths, word types and constant tables for the Euler angle to
// quaternion pipeline.
// ----------------------------------------------------------------------------
package eaq_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 8;
   localparam int OUT_FRAC_BITS_DEF   = 15;
   localparam int TRIG_ITERATIONS_DEF = 16;

   localparam int ANG_W = 18;
   localparam int OUT_W = 16;
   localparam int Q     = 30;
   localparam int CW    = 33;
   localparam int LANES = 3;

   localparam int LANE_YAW   = 0;
   localparam int LANE_PITCH = 1;
   localparam int LANE_ROLL  = 2;

   localparam logic [33:0] PI_OVER_360_Q40 = 34'd9595049034;

   localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sd32767;
   localparam logic signed [OUT_W-1:0] OUT_MIN = -16'sd32768;

   typedef struct packed {
      logic                 neg_cos;
      logic signed [CW-1:0] z;
   } prep_type;

   typedef struct packed {
      logic                 neg_cos;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } rot_type;

   typedef struct packed {
      logic signed [CW-1:0] c;
      logic signed [CW-1:0] s;
   } cs_type;

   function automatic logic signed [CW-1:0] atan_q30(input int i);
      logic signed [CW-1:0] v;
      case (i)
         0:  v = 33'sd843314856;
         1:  v = 33'sd497837829;
         2:  v = 33'sd263043836;
         3:  v = 33'sd133525158;
         4:  v = 33'sd67021686;
         5:  v = 33'sd33543515;
         6:  v = 33'sd16775850;
         7:  v = 33'sd8388437;
         8:  v = 33'sd4194282;
         9:  v = 33'sd2097149;
         10: v = 33'sd1048575;
         11: v = 33'sd524287;
         12: v = 33'sd262143;
         13: v = 33'sd131071;
         14: v = 33'sd65535;
         15: v = 33'sd32767;
         16: v = 33'sd16383;
         17: v = 33'sd8191;
         18: v = 33'sd4095;
         19: v = 33'sd2047;
         20: v = 33'sd1023;
         21: v = 33'sd511;
         22: v = 33'sd255;
         23: v = 33'sd127;
         24: v = 33'sd63;
         25: v = 33'sd31;
         26: v = 33'sd15;
         27: v = 33'sd7;
         28: v = 33'sd3;
         29: v = 33'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Reciprocal of the rotation gain in Q30, evaluated at elaboration
   function automatic longint unsigned inv_gain_q30(input int n);
      longint unsigned g2;
      longint unsigned v;
      longint unsigned res;
      longint unsigned bit_v;
      longint unsigned g;
      longint unsigned quo;
      longint unsigned rem;
      int i;
      g2 = 64'd1 << Q;
      for (i = 0; i < n && i < 32; i++) begin
         g2 = g2 + (g2 >> (2 * i));
      end
      v     = g2 << Q;
      res   = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (v >= res + bit_v) begin
            v   = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      g = (res == 0) ? 64'd1 : res;
      quo = 0;
      rem = 0;
      for (i = 60; i >= 0; i--) begin
         rem = (rem << 1) | ((i == 60) ? 64'd1 : 64'd0);
         if (rem >= g) begin
            rem = rem - g;
            quo = quo | (64'd1 << i);
         end
      end
      return quo;
   endfunction

   // Q30 product, floored back to Q30
   function automatic logic signed [CW-1:0] mulq(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
      logic signed [2*CW-1:0] p;
      p = a * b;
      return p[Q+CW-1:Q];
   endfunction

endpackage

[rtl/core/eaq_prep.sv]
// ----------------------------------------------------------------------------
// eaq_prep
// Two stages: fold each angle into a quarter turn of half angle, then scale
// degrees to a Q30 radian half angle.
// ----------------------------------------------------------------------------
module eaq_prep #(
   parameter int ANGLE_FRAC_BITS = eaq_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          en,
   input  logic                                          in_valid,
   input  logic signed [eaq_pkg::LANES-1:0][eaq_pkg::ANG_W-1:0] in_ang,
   output logic                                          out_valid,
   output eaq_pkg::prep_type [eaq_pkg::LANES-1:0]        out_prep
);

   localparam int RED_W  = (ANGLE_FRAC_BITS + 12 > 20) ? ANGLE_FRAC_BITS + 12 : 20;
   localparam int MAG_W  = ANGLE_FRAC_BITS + 8;
   localparam int PROD_W = MAG_W + 35;
   localparam logic signed [RED_W-1:0] FULL    = RED_W'(720 << ANGLE_FRAC_BITS);
   localparam logic signed [RED_W-1:0] HALF    = RED_W'(360 << ANGLE_FRAC_BITS);
   localparam logic signed [RED_W-1:0] QUARTER = RED_W'(180 << ANGLE_FRAC_BITS);
   localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (9 + ANGLE_FRAC_BITS);

   logic                  v1_ff;
   logic [MAG_W-1:0]      mag_ff  [eaq_pkg::LANES];
   logic [MAG_W-1:0]      mag_in  [eaq_pkg::LANES];
   logic                  nega_ff [eaq_pkg::LANES];
   logic                  nega_in [eaq_pkg::LANES];
   logic                  negc_ff [eaq_pkg::LANES];
   logic                  negc_in [eaq_pkg::LANES];
   logic                  v2_ff;
   eaq_pkg::prep_type [eaq_pkg::LANES-1:0] prep_ff;
   eaq_pkg::prep_type [eaq_pkg::LANES-1:0] prep_in;

   for (genvar l = 0; l < eaq_pkg::LANES; l++) begin : g_lane
      logic signed [RED_W-1:0]  a;
      logic signed [RED_W-1:0]  r0;
      logic signed [RED_W-1:0]  r1;
      logic signed [RED_W-1:0]  ra;
      logic [PROD_W-1:0]        prod;
      logic [PROD_W-1:0]        zm;
      logic signed [eaq_pkg::CW-1:0] zs;

      always_comb begin
         a = RED_W'(signed'(in_ang[l]));
         if (a >= HALF) begin
            r0 = a - FULL;
         end else if (a < -HALF) begin
            r0 = a + FULL;
         end else begin
            r0 = a;
         end
         negc_in[l] = 1'b0;
         r1 = r0;
         if (r0 > QUARTER) begin
            r1 = HALF - r0;
            negc_in[l] = 1'b1;
         end else if (r0 < -QUARTER) begin
            r1 = -HALF - r0;
            negc_in[l] = 1'b1;
         end
         nega_in[l] = r1[RED_W-1];
         ra = nega_in[l] ? -r1 : r1;
         mag_in[l] = ra[MAG_W-1:0];
      end

      always_comb begin
         prod = PROD_W'(mag_ff[l]) * PROD_W'(eaq_pkg::PI_OVER_360_Q40);
         zm   = (prod + RND) >> (10 + ANGLE_FRAC_BITS);
         zs   = signed'(zm[eaq_pkg::CW-1:0]);
         prep_in[l].neg_cos = negc_ff[l];
         prep_in[l].z       = nega_ff[l] ? -zs : zs;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            mag_ff[l]  <= mag_in[l];
            nega_ff[l] <= nega_in[l];
            negc_ff[l] <= negc_in[l];
            prep_ff[l] <= prep_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_prep  = prep_ff;

endmodule

[rtl/core/eaq_cordic.sv]
// ----------------------------------------------------------------------------
// eaq_cordic
// Unrolled rotation-mode CORDIC, one iteration per register stage, three
// lanes side by side.
// ----------------------------------------------------------------------------
module eaq_cordic #(
   parameter int TRIG_ITERATIONS = eaq_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  eaq_pkg::prep_type [eaq_pkg::LANES-1:0] in_prep,
   output logic                                   out_valid,
   output eaq_pkg::cs_type [eaq_pkg::LANES-1:0]   out_cs
);

   localparam longint unsigned K_RAW = eaq_pkg::inv_gain_q30(TRIG_ITERATIONS);
   localparam logic signed [eaq_pkg::CW-1:0] K = eaq_pkg::CW'(K_RAW);

   logic                                  v_ff  [TRIG_ITERATIONS];
   eaq_pkg::rot_type [eaq_pkg::LANES-1:0] st_ff [TRIG_ITERATIONS];
   eaq_pkg::rot_type [eaq_pkg::LANES-1:0] st_in [TRIG_ITERATIONS];

   for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_iter
      localparam logic signed [eaq_pkg::CW-1:0] ATAN = eaq_pkg::atan_q30(i);
      eaq_pkg::rot_type [eaq_pkg::LANES-1:0] cur;
      logic                                  cur_v;

      if (i == 0) begin : g_first
         always_comb begin
            cur_v = in_valid;
            for (int l = 0; l < eaq_pkg::LANES; l++) begin
               cur[l].neg_cos = in_prep[l].neg_cos;
               cur[l].x       = K;
               cur[l].y       = '0;
               cur[l].z       = in_prep[l].z;
            end
         end
      end else begin : g_rest
         always_comb begin
            cur_v = v_ff[i-1];
            cur   = st_ff[i-1];
         end
      end

      always_comb begin
         for (int l = 0; l < eaq_pkg::LANES; l++) begin
            st_in[i][l].neg_cos = cur[l].neg_cos;
            if (!cur[l].z[eaq_pkg::CW-1]) begin
               st_in[i][l].x = cur[l].x - (cur[l].y >>> i);
               st_in[i][l].y = cur[l].y + (cur[l].x >>> i);
               st_in[i][l].z = cur[l].z - ATAN;
            end else begin
               st_in[i][l].x = cur[l].x + (cur[l].y >>> i);
               st_in[i][l].y = cur[l].y - (cur[l].x >>> i);
               st_in[i][l].z = cur[l].z + ATAN;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= cur_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < eaq_pkg::LANES; l++) begin
         out_cs[l].c = st_ff[TRIG_ITERATIONS-1][l].neg_cos ?
                       -st_ff[TRIG_ITERATIONS-1][l].x : st_ff[TRIG_ITERATIONS-1][l].x;
         out_cs[l].s = st_ff[TRIG_ITERATIONS-1][l].y;
      end
   end

   assign out_valid = v_ff[TRIG_ITERATIONS-1];

endmodule

[rtl/core/eaq_qmul.sv]
// ----------------------------------------------------------------------------
// eaq_qmul
// Three stages: yaw-roll products, products with pitch, then sum, round and
// saturate to the quaternion word.
// ----------------------------------------------------------------------------
module eaq_qmul #(
   parameter int OUT_FRAC_BITS = eaq_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        en,
   input  logic                                        in_valid,
   input  eaq_pkg::cs_type [eaq_pkg::LANES-1:0]        in_cs,
   output logic                                        out_valid,
   output logic signed [eaq_pkg::OUT_W-1:0]            out_w,
   output logic signed [eaq_pkg::OUT_W-1:0]            out_x,
   output logic signed [eaq_pkg::OUT_W-1:0]            out_y,
   output logic signed [eaq_pkg::OUT_W-1:0]            out_z
);

   localparam int CW  = eaq_pkg::CW;
   localparam int SW  = CW + 2;
   localparam int SH  = eaq_pkg::Q - OUT_FRAC_BITS;
   localparam int RND = (SH > 0) ? (1 << (SH - 1)) : 0;

   function automatic logic signed [eaq_pkg::OUT_W-1:0] to_out(
         input logic signed [SW-1:0] v);
      logic signed [SW-1:0] t;
      t = (v + SW'(RND)) >>> SH;
      if (t > SW'(eaq_pkg::OUT_MAX)) begin
         t = SW'(eaq_pkg::OUT_MAX);
      end else if (t < SW'(eaq_pkg::OUT_MIN)) begin
         t = SW'(eaq_pkg::OUT_MIN);
      end
      return t[eaq_pkg::OUT_W-1:0];
   endfunction

   logic                 v1_ff, v2_ff, v3_ff;
   logic signed [CW-1:0] cycr_ff, sysr_ff, cysr_ff, sycr_ff, cp_ff, sp_ff;
   logic signed [CW-1:0] wa_ff, wb_ff, xa_ff, xb_ff, ya_ff, yb_ff, za_ff, zb_ff;
   logic signed [eaq_pkg::OUT_W-1:0] w_ff, x_ff, y_ff, z_ff;
   logic signed [eaq_pkg::OUT_W-1:0] w_in, x_in, y_in, z_in;

   always_comb begin
      w_in = to_out(SW'(wa_ff) + SW'(wb_ff));
      x_in = to_out(SW'(xa_ff) - SW'(xb_ff));
      y_in = to_out(SW'(ya_ff) + SW'(yb_ff));
      z_in = to_out(SW'(za_ff) - SW'(zb_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cycr_ff <= eaq_pkg::mulq(in_cs[eaq_pkg::LANE_YAW].c, in_cs[eaq_pkg::LANE_ROLL].c);
         sysr_ff <= eaq_pkg::mulq(in_cs[eaq_pkg::LANE_YAW].s, in_cs[eaq_pkg::LANE_ROLL].s);
         cysr_ff <= eaq_pkg::mulq(in_cs[eaq_pkg::LANE_YAW].c, in_cs[eaq_pkg::LANE_ROLL].s);
         sycr_ff <= eaq_pkg::mulq(in_cs[eaq_pkg::LANE_YAW].s, in_cs[eaq_pkg::LANE_ROLL].c);
         cp_ff   <= in_cs[eaq_pkg::LANE_PITCH].c;
         sp_ff   <= in_cs[eaq_pkg::LANE_PITCH].s;
         wa_ff   <= eaq_pkg::mulq(cycr_ff, cp_ff);
         wb_ff   <= eaq_pkg::mulq(sysr_ff, sp_ff);
         xa_ff   <= eaq_pkg::mulq(cysr_ff, cp_ff);
         xb_ff   <= eaq_pkg::mulq(sycr_ff, sp_ff);
         ya_ff   <= eaq_pkg::mulq(cycr_ff, sp_ff);
         yb_ff   <= eaq_pkg::mulq(sysr_ff, cp_ff);
         za_ff   <= eaq_pkg::mulq(sycr_ff, cp_ff);
         zb_ff   <= eaq_pkg::mulq(cysr_ff, sp_ff);
         w_ff    <= w_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_w     = w_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

[rtl/core/euler_angles_to_quaternion.sv]
// ----------------------------------------------------------------------------
// euler_angles_to_quaternion
// Yaw-pitch-roll angles in degrees to a unit quaternion in signed Q1.15.
//
// Input word: req_yaw_deg, req_pitch_deg, req_roll_deg, signed degrees with
// ANGLE_FRAC_BITS fraction bits; any bit pattern is taken, angles wrap every
// 720 degrees. Output word: rsp_quat_w/x/y/z, rounded and saturated.
// Both channels use valid/ready; one word may be accepted every cycle while
// the receiver does not stall. The pipeline has two stages of angle folding
// and scaling, one stage per CORDIC iteration, and three of products and
// final rounding. Throughput is one word per cycle when the output does not
// stall, set by the fully unrolled CORDIC and multiplier stages.
// All stages advance together; when the receiver holds rsp_ready low with a
// word waiting, the whole pipeline holds and req_ready drops in the same
// cycle. Nothing is lost or repeated across a stall.
// Reset clears every stage valid bit; no words are in flight afterwards.
// ----------------------------------------------------------------------------
module euler_angles_to_quaternion #(
   parameter int ANGLE_FRAC_BITS = eaq_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int OUT_FRAC_BITS   = eaq_pkg::OUT_FRAC_BITS_DEF,
   parameter int TRIG_ITERATIONS = eaq_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [eaq_pkg::ANG_W-1:0]    req_yaw_deg,
   input  logic signed [eaq_pkg::ANG_W-1:0]    req_pitch_deg,
   input  logic signed [eaq_pkg::ANG_W-1:0]    req_roll_deg,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [eaq_pkg::OUT_W-1:0]    rsp_quat_w,
   output logic signed [eaq_pkg::OUT_W-1:0]    rsp_quat_x,
   output logic signed [eaq_pkg::OUT_W-1:0]    rsp_quat_y,
   output logic signed [eaq_pkg::OUT_W-1:0]    rsp_quat_z
);

   logic                                          en;
   logic signed [eaq_pkg::LANES-1:0][eaq_pkg::ANG_W-1:0] ang;
   logic                                          prep_valid;
   eaq_pkg::prep_type [eaq_pkg::LANES-1:0]        prep;
   logic                                          cs_valid;
   eaq_pkg::cs_type [eaq_pkg::LANES-1:0]          cs;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   assign ang[eaq_pkg::LANE_YAW]   = req_yaw_deg;
   assign ang[eaq_pkg::LANE_PITCH] = req_pitch_deg;
   assign ang[eaq_pkg::LANE_ROLL]  = req_roll_deg;

   eaq_prep #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_ang    (ang),
      .out_valid (prep_valid),
      .out_prep  (prep)
   );

   eaq_cordic #(
      .TRIG_ITERATIONS (TRIG_ITERATIONS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prep_valid),
      .in_prep   (prep),
      .out_valid (cs_valid),
      .out_cs    (cs)
   );

   eaq_qmul #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_qmul (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cs_valid),
      .in_cs     (cs),
      .out_valid (rsp_valid),
      .out_w     (rsp_quat_w),
      .out_x     (rsp_quat_x),
      .out_y     (rsp_quat_y),
      .out_z     (rsp_quat_z)
   );

endmodule

[rtl/core/eaq_checker.sv]
// ----------------------------------------------------------------------------
// eaq_checker
// Port-level checks on the Euler angle to quaternion pipeline.
// ----------------------------------------------------------------------------
module eaq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic signed [eaq_pkg::ANG_W-1:0] req_yaw_deg,
   input logic signed [eaq_pkg::ANG_W-1:0] req_pitch_deg,
   input logic signed [eaq_pkg::ANG_W-1:0] req_roll_deg,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [eaq_pkg::OUT_W-1:0] rsp_quat_w,
   input logic signed [eaq_pkg::OUT_W-1:0] rsp_quat_x,
   input logic signed [eaq_pkg::OUT_W-1:0] rsp_quat_y,
   input logic signed [eaq_pkg::OUT_W-1:0] rsp_quat_z
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quat_w) &&
      $stable(rsp_quat_x) && $stable(rsp_quat_y) && $stable(rsp_quat_z))
      else $error("result word changed while stalled");

   a_ready_follows_stall: assert property (@(posedge clock)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z}))
      else $error("result word carries unknown bits");

endmodule

bind euler_angles_to_quaternion eaq_checker u_eaq_checker (.*);
